@@ src/assert_macros.svh @@
// Shared assertion macros. Expect clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/ahpd_pkg.sv @@
package ahpd_pkg;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_BODY  = 2'd1,
        PH_SKIP  = 2'd2
    } phase_t;

    localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
    localparam logic [1:0] STATUS_HDR_ERR = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

    localparam logic       CFG_CHANNEL_ID = 1'b0;
    localparam logic       CFG_MAX_LEN    = 1'b1;

    localparam logic [15:0] CHANNEL_ID_RESET = 16'h0101;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd800;

    localparam logic [7:0] HDR_TAG = 8'h05;
    localparam int         HDR_LEN = 5;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } res_t;

endpackage

@@ src/ahpd_core.sv @@
module ahpd_core #(
    parameter int PACKET_BYTES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_data,
    input  logic [15:0]   channel_id,
    input  logic [15:0]   max_len,
    output ahpd_pkg::res_t res
);
    import ahpd_pkg::*;

    localparam int POS_W = $clog2(PACKET_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      remain_reg, remain_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    phase_t           phase_reg, phase_next, phase_step;

    logic [7:0]  hdr_exp;
    logic [15:0] len_word;
    logic [15:0] remain_dec;
    logic        pos_last;

    assign len_word   = {len_hi_reg, rx_data};
    assign remain_dec = remain_reg - 16'd1;
    assign pos_last   = (pos_reg == POS_W'(PACKET_BYTES - 1));

    always_comb
    begin
        case (pos_reg)
            POS_W'(0): hdr_exp = channel_id[15:8];
            POS_W'(1): hdr_exp = channel_id[7:0];
            POS_W'(2): hdr_exp = HDR_TAG;
            POS_W'(3): hdr_exp = seq_reg[15:8];
            default:   hdr_exp = seq_reg[7:0];
        endcase
    end

    // Byte decode
    always_comb
    begin
        phase_step  = phase_reg;
        remain_next = remain_reg;
        len_hi_next = len_hi_reg;
        res         = '0;
        unique case (phase_reg) inside
            PH_FIRST, PH_BODY:
            begin
                if (pos_reg < POS_W'(HDR_LEN))
                begin
                    if (rx_data != hdr_exp)
                    begin
                        res.valid  = 1'b1;
                        res.status = STATUS_HDR_ERR;
                        phase_step = PH_SKIP;
                    end
                end
                else if (phase_reg == PH_FIRST)
                begin
                    if (pos_reg == POS_W'(HDR_LEN))
                    begin
                        len_hi_next = rx_data;
                    end
                    else if (len_word > max_len)
                    begin
                        res.valid  = 1'b1;
                        res.status = STATUS_LEN_ERR;
                        phase_step = PH_SKIP;
                    end
                    else if (len_word == 16'd0)
                    begin
                        phase_step = PH_SKIP;
                    end
                    else
                    begin
                        remain_next = len_word;
                        phase_step  = PH_BODY;
                    end
                end
                else
                begin
                    res.valid   = 1'b1;
                    res.data    = rx_data;
                    remain_next = remain_dec;
                    if (remain_dec == 16'd0)
                    begin
                        res.last   = 1'b1;
                        phase_step = PH_SKIP;
                    end
                end
            end
            default: ;  // skipping, unused code too
        endcase
    end

    // Packet boundary
    always_comb
    begin
        phase_next = phase_step;
        seq_next   = seq_reg;
        pos_next   = pos_reg + POS_W'(1);
        if (pos_last)
        begin
            pos_next = '0;
            if (phase_step == PH_BODY)
            begin
                seq_next = seq_reg + 16'd1;
            end
            else
            begin
                phase_next = PH_FIRST;
                seq_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            seq_reg    <= '0;
            remain_reg <= '0;
            len_hi_reg <= '0;
            phase_reg  <= PH_FIRST;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            seq_reg    <= seq_next;
            remain_reg <= remain_next;
            len_hi_reg <= len_hi_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

@@ src/apdu_hid_packet_deframer.sv @@
// Response deframer for APDU traffic carried in fixed-size HID packets.
// Input channel: one received byte per request on rx_byte (in_valid/in_ready).
// Output channel: one result per request that yields one (out_valid/out_ready):
//   status 0 carries a payload byte, last_of_message marks the final one;
//   status 1 flags a header mismatch, status 2 a length over the limit.
// Matching header bytes, accepted length bytes and padding yield no result.
// Configuration: cfg_write with cfg_index 0 sets the channel, 1 the length
//   limit; write only while the block is idle.
// Path: a request accepted into the input register passes the decode stage
//   into the result register. Throughput: one byte per cycle while the
//   receiver takes results, set by the single decode stage between the two.
// Reset: output empty, input stage empty, waiting for the first packet of a
//   message; channel 0x0101 and limit 800.
// Receiver stall: the result register holds; the input stage keeps taking
//   bytes that yield no result, and stops on the first that does.
module apdu_hid_packet_deframer #(
    parameter int PACKET_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        last_of_message,
    output logic [1:0]  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import ahpd_pkg::*;

    logic [15:0] channel_id_reg;
    logic [15:0] max_len_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic [1:0]  out_status_reg;

    res_t        res;
    logic        advance;

    // The staged byte moves on when its result has room, or when it has none.
    assign advance  = in_valid_reg && (!res.valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    ahpd_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_data    (in_byte_reg),
        .channel_id (channel_id_reg),
        .max_len    (max_len_reg),
        .res        (res)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_id_reg <= CHANNEL_ID_RESET;
            max_len_reg    <= MAX_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_ID: channel_id_reg <= cfg_data;
                CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_data_reg   <= res.data;
            out_last_reg   <= res.last;
            out_status_reg <= res.status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_byte    = out_data_reg;
    assign last_of_message = out_last_reg;
    assign status          = out_status_reg;

endmodule

@@ src/ahpd_checker.sv @@
`include "assert_macros.svh"

module ahpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  payload_byte,
    input logic        last_of_message,
    input logic [1:0]  status
);
    import ahpd_pkg::*;

    logic [10:0] res_bits;
    logic        is_err;
    logic        carries_data;

    assign res_bits     = {payload_byte, last_of_message, status};
    assign is_err       = (status != STATUS_PAYLOAD);
    assign carries_data = (payload_byte != 8'd0) || last_of_message;

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result shown during reset")
    `ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")
    `ASSERT_RUN(a_data_hold, out_valid && !out_ready |=> $stable(res_bits), "stalled result changed")
    `ASSERT_RUN(a_last_is_payload, out_valid && last_of_message |-> !is_err, "last mark on an error")
    `ASSERT_RUN(a_err_clean, out_valid && is_err |-> !carries_data, "error result carries data")

endmodule

bind apdu_hid_packet_deframer ahpd_checker u_ahpd_checker (.*);

@@ test/hid_deframe_checker.sv @@
`timescale 1ns / 1ps

module hid_deframe_checker #(
    parameter int PACKET_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  payload_byte,
    input  logic        last_of_message,
    input  logic [1:0]  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          results_owed
);
    import ahpd_pkg::*;

    // Shadow of the configuration and of the deframing state.
    logic [15:0] chan_id;
    logic [15:0] len_limit;
    logic [5:0]  rx_pos;
    logic [15:0] want_seq;
    logic [15:0] body_left;
    logic [7:0]  len_hi;
    phase_t      rx_phase;

    res_t        owed_q[$];
    int          errors = 0;

    function automatic res_t deframe_step(input logic [7:0] b);
        res_t        r;
        logic [7:0]  hdr;
        logic [15:0] len;
        r = '0;
        if (rx_phase == PH_FIRST || rx_phase == PH_BODY) begin
            if (rx_pos < HDR_LEN) begin
                case (rx_pos)
                    6'd0:    hdr = chan_id[15:8];
                    6'd1:    hdr = chan_id[7:0];
                    6'd2:    hdr = HDR_TAG;
                    6'd3:    hdr = want_seq[15:8];
                    default: hdr = want_seq[7:0];
                endcase
                if (b != hdr) begin
                    r.valid  = 1'b1;
                    r.status = STATUS_HDR_ERR;
                    rx_phase = PH_SKIP;
                end
            end else if (rx_phase == PH_FIRST) begin
                if (rx_pos == HDR_LEN) begin
                    len_hi = b;
                end else begin
                    len = {len_hi, b};
                    if (len > len_limit) begin
                        r.valid  = 1'b1;
                        r.status = STATUS_LEN_ERR;
                        rx_phase = PH_SKIP;
                    end else if (len == 16'd0) begin
                        rx_phase = PH_SKIP;
                    end else begin
                        body_left = len;
                        rx_phase  = PH_BODY;
                    end
                end
            end else begin
                r.valid   = 1'b1;
                r.data    = b;
                r.status  = STATUS_PAYLOAD;
                body_left = body_left - 16'd1;
                if (body_left == 16'd0) begin
                    r.last   = 1'b1;
                    rx_phase = PH_SKIP;
                end
            end
        end
        // packet boundary: continue the message or re-arm for a new one
        if (rx_pos == PACKET_BYTES - 1) begin
            rx_pos = '0;
            if (rx_phase == PH_BODY) begin
                want_seq = want_seq + 16'd1;
            end else begin
                rx_phase = PH_FIRST;
                want_seq = '0;
            end
        end else begin
            rx_pos = rx_pos + 6'd1;
        end
        return r;
    endfunction

    task automatic note_fail(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        res_t got;
        if (!rst_n) begin
            chan_id      = CHANNEL_ID_RESET;
            len_limit    = MAX_LEN_RESET;
            rx_pos       = '0;
            want_seq     = '0;
            body_left    = '0;
            len_hi       = '0;
            rx_phase     = PH_FIRST;
            owed_q.delete();
            results_owed <= 0;
            fail_count   <= errors;
        end else begin
            if (cfg_write) begin
                if (cfg_index == CFG_CHANNEL_ID)
                    chan_id = cfg_data;
                else
                    len_limit = cfg_data;
            end
            if (out_valid && out_ready) begin
                if (owed_q.size() == 0) begin
                    note_fail($sformatf("unexpected result data=%02h last=%0d status=%0d",
                                        payload_byte, last_of_message, status));
                end else begin
                    want = owed_q.pop_front();
                    if (payload_byte !== want.data || last_of_message !== want.last ||
                        status !== want.status)
                        note_fail($sformatf(
                            "mismatch: exp data=%02h last=%0d status=%0d, got data=%02h last=%0d status=%0d",
                            want.data, want.last, want.status,
                            payload_byte, last_of_message, status));
                end
            end
            if (in_valid && in_ready) begin
                got = deframe_step(rx_byte);
                if (got.valid)
                    owed_q.insert(owed_q.size(), got);
            end
            results_owed <= owed_q.size();
            fail_count   <= errors;
        end
    end

endmodule

@@ test/tb_apdu_hid_packet_deframer.sv @@
`timescale 1ns / 1ps

module tb_apdu_hid_packet_deframer;
    import ahpd_pkg::*;

    localparam int PKT         = 64;
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake or register write before giving up
    localparam int NO_FAULT    = -1;
    localparam int NO_ABORT    = -1;
    localparam int FIRST_ROOM  = PKT - HDR_LEN - 2;   // payload room in the first packet
    localparam int NEXT_ROOM   = PKT - HDR_LEN;       // and in every later one

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  payload_byte;
    logic        last_of_message;
    logic [1:0]  status;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_CHANNEL_ID;
    logic [15:0] cfg_data = '0;

    int          fail_count;
    int          results_owed;

    // Stimulus view of the current configuration.
    logic [15:0] cur_chan = CHANNEL_ID_RESET;
    logic [15:0] cur_limit = MAX_LEN_RESET;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          live_bytes = 0;   // header, length and payload bytes sent
    int          quiet_cycles = 0;

    apdu_hid_packet_deframer #(
        .PACKET_BYTES (PKT)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .last_of_message (last_of_message),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    hid_deframe_checker #(
        .PACKET_BYTES (PKT)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .last_of_message (last_of_message),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: back-pressure at the rate of the current phase.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    // Watchdog: any request moving on either channel, or a register write, restarts it.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request on the input channel. Idle gaps come before valid is raised,
    // so valid never drops while a request is waiting.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drain: input idle, every owed result delivered, then a short pause
    // so the input and result stages empty before any configuration write.
    // The first edge lets the owed count take in the last byte sent.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both registers, back to back, only ever called after settle().
    task automatic set_config(input logic [15:0] chan, input logic [15:0] lim);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CHANNEL_ID;
        cfg_data  <= chan;
        @(posedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_chan  = chan;
        cur_limit = lim;
    endtask

    function automatic int packets_for(input int len);
        if (len <= FIRST_ROOM)
            return 1;
        return 1 + (len - FIRST_ROOM + NEXT_ROOM - 1) / NEXT_ROOM;
    endfunction

    // A whole message as a train of full packets. bad_pkt/bad_pos corrupts one
    // header byte; abort_pkt cuts the message off before that packet goes out.
    // Bytes after an error, a rejected length or the end of the payload are
    // random padding, which the block skips up to the packet boundary.
    task automatic send_message(input int len, input int bad_pkt, input int bad_pos,
                                input int abort_pkt);
        logic [7:0] hdr [0:6];
        int         sent;
        int         pos;
        int         pk;
        int         hdr_bytes;
        bit         body_ok;
        bit         done;
        sent = 0;
        pk   = 0;
        done = 1'b0;
        while (!done && pk != abort_pkt) begin
            hdr[0] = cur_chan[15:8];
            hdr[1] = cur_chan[7:0];
            hdr[2] = HDR_TAG;
            hdr[3] = pk[15:8];
            hdr[4] = pk[7:0];
            hdr[5] = len[15:8];
            hdr[6] = len[7:0];
            if (pk == bad_pkt)
                hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(1, 255));
            body_ok   = (pk != bad_pkt) && (len != 0) && (len <= int'(cur_limit));
            hdr_bytes = (pk == 0) ? HDR_LEN + 2 : HDR_LEN;
            for (pos = 0; pos < hdr_bytes; pos++) begin
                push_byte(hdr[pos]);
                live_bytes++;
            end
            for (; pos < PKT; pos++) begin
                if (body_ok && sent < len) begin
                    push_byte(8'($urandom_range(0, 255)));
                    sent++;
                    live_bytes++;
                end else begin
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
            done = !body_ok || sent >= len;
            pk++;
        end
    endtask

    // A packet of pure line noise: almost always a header error, then skipped.
    task automatic noise_packet();
        repeat (PKT) push_byte(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed messages with random content, short ones dominating;
    // the rest are header faults, oversize and zero lengths, cut-off messages
    // (whose successor then trips the sequence check) and noise.
    task automatic random_traffic(input int quota);
        int first;
        int pick;
        int lim;
        int span_s;
        int span_b;
        int len;
        first  = live_bytes;
        lim    = int'(cur_limit);
        span_s = (lim < 60) ? lim : 60;
        span_b = (lim < 150) ? lim : 150;
        while (live_bytes - first < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                if (lim == 0)
                    send_message(0, NO_FAULT, 0, NO_ABORT);
                else
                    send_message($urandom_range(1, (pick < 8) ? span_b : span_s),
                                 NO_FAULT, 0, NO_ABORT);
            end else if (pick < 75) begin
                len = (lim == 0) ? 0 : $urandom_range(1, span_b);
                send_message(len, $urandom_range(0, packets_for(len) - 1),
                             $urandom_range(0, HDR_LEN - 1), NO_ABORT);
            end else if (pick < 83) begin
                if (lim < 65535)
                    send_message($urandom_range(lim + 1, 65535), NO_FAULT, 0, NO_ABORT);
                else
                    send_message($urandom_range(1, span_s), NO_FAULT, 0, NO_ABORT);
            end else if (pick < 88) begin
                send_message(0, NO_FAULT, 0, NO_ABORT);
            end else if (pick < 95 && lim > FIRST_ROOM) begin
                len = $urandom_range(FIRST_ROOM + 1, span_b);
                send_message(len, NO_FAULT, 0, $urandom_range(1, packets_for(len) - 1));
            end else begin
                noise_packet();
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- phase 0: no idling on either side ----
        src_idle_pct  = 0;
        snk_stall_pct = 0;

        // Reset configuration: single byte, exact two-packet fill, zero
        // length, length just above the limit.
        send_message(1, NO_FAULT, 0, NO_ABORT);
        send_message(FIRST_ROOM + NEXT_ROOM, NO_FAULT, 0, NO_ABORT);
        send_message(0, NO_FAULT, 0, NO_ABORT);
        send_message(int'(MAX_LEN_RESET) + 1, NO_FAULT, 0, NO_ABORT);
        // header error on the tag of a first packet
        send_message(10, 0, 2, NO_ABORT);
        // sequence error in a continuation packet
        send_message(100, 1, 3, NO_ABORT);

        // Lowest settings: every non-zero length is over the limit.
        settle();
        set_config(16'h0000, 16'd0);
        send_message(1, NO_FAULT, 0, NO_ABORT);

        // Highest settings: the longest length is accepted; the message is
        // cut off after its first packet, so the next one trips the sequence.
        settle();
        set_config(16'hFFFF, 16'hFFFF);
        send_message(65535, NO_FAULT, 0, 1);
        send_message(3, NO_FAULT, 0, NO_ABORT);

        settle();
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(300, 800)));
        random_traffic(50);

        // ---- phase 1: sender mostly idle ----
        settle();
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(60, 300)));
        src_idle_pct  = 83;
        snk_stall_pct = 0;
        random_traffic(50);

        // ---- phase 2: receiver mostly stalled ----
        settle();
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(300, 1000)));
        src_idle_pct  = 0;
        snk_stall_pct = 83;
        random_traffic(50);

        // ---- phase 3: light idling on both sides ----
        settle();
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(100, 800)));
        src_idle_pct  = 18;
        snk_stall_pct = 18;
        random_traffic(50);

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
